// ===== sv/dmpl_pkg.sv =====
`default_nettype none
package dmpl_pkg;

  localparam int MAX_STATES  = 256;
  localparam int MAX_LETTERS = 16;

  localparam int ST_W     = $clog2(MAX_STATES);
  localparam int LT_W     = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int CNT_W    = ST_W + 1;
  localparam int TT_DEPTH = MAX_STATES * MAX_LETTERS;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int SIDX_W  = 9;
  localparam int LET_W   = 5;
  localparam int TGT_W   = 8;
  localparam int RES_W   = 9;
  localparam int ALPHA_W = 5;
  localparam int STATE_W = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(2);

  typedef enum logic [MODE_W-1:0] {
    MODE_FLAG  = 2'd0,
    MODE_TRANS = 2'd1,
    MODE_BUILD = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_ALPHA   = 2'd0,
    REG_HIGHEST = 2'd1,
    REG_INITIAL = 2'd2
  } reg_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] letter_cnt;
    logic [STATE_W-1:0] last_state;
    logic [STATE_W-1:0] initial_state;
  } cfg_t;

  typedef struct packed {
    logic [RES_W-1:0] target;
    logic             is_final;
    logic [RES_W-1:0] init_state;
    logic [RES_W-1:0] high_state;
    logic             built;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/dmpl_ram.sv =====
`default_nettype none
module dmpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/dmpl_cfg.sv =====
`default_nettype none
module dmpl_cfg import dmpl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_ALPHA:   cfg_d.letter_cnt    = pwdata[ALPHA_W-1:0];
        REG_HIGHEST: cfg_d.last_state    = pwdata[STATE_W-1:0];
        REG_INITIAL: cfg_d.initial_state = pwdata[STATE_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_ALPHA:   prdata = PDATA_W'(cfg_q.letter_cnt);
      REG_HIGHEST: prdata = PDATA_W'(cfg_q.last_state);
      REG_INITIAL: prdata = PDATA_W'(cfg_q.initial_state);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.letter_cnt    <= ALPHA_RST;
      cfg_q.last_state    <= '0;
      cfg_q.initial_state <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dmpl_core.sv =====
`default_nettype none
module dmpl_core import dmpl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [SIDX_W-1:0] state_index_i,
  input  wire logic [LET_W-1:0]  letter_i,
  input  wire logic [TGT_W-1:0]  target_state_i,
  input  wire logic              final_flag_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      res_t              res_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_BLD_INIT = 11'b000_0000_0010,
    S_BLD_CHK  = 11'b000_0000_0100,
    S_BLD_RD   = 11'b000_0000_1000,
    S_BLD_WR   = 11'b000_0001_0000,
    S_BLD_END  = 11'b000_0010_0000,
    S_RD_DEC   = 11'b000_0100_0000,
    S_RD_TT    = 11'b000_1000_0000,
    S_RD_O2N   = 11'b001_0000_0000,
    S_RD_FIN   = 11'b010_0000_0000,
    S_PUSH     = 11'b100_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [SIDX_W-1:0]   s_q, s_d;
  logic [LET_W-1:0]    l_q, l_d;
  logic [ST_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    binit_q, binit_d;
  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic [ST_W-1:0]     hi_q, hi_d;
  logic                built_q, built_d;
  logic                eps_q, eps_d;
  logic [RES_W-1:0]    tgt_q, tgt_d;
  logic                fin_q, fin_d;

  logic                accept, ok;
  logic [CNT_W-1:0]    cnt_inc;
  logic [ST_W-1:0]     init_st;

  // memory ports
  logic                fm_we, fm_rd;
  logic [ST_W-1:0]     fm_raddr;
  logic                tt_we;
  logic [$clog2(TT_DEPTH)-1:0] tt_waddr, tt_raddr;
  logic [ST_W-1:0]     tt_rd;
  logic                o2n_we;
  logic [CNT_W-1:0]    o2n_wdata, o2n_rd;
  logic                n2o_we;
  logic [ST_W-1:0]     n2o_rd;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign ok         = (l_q != '0) && (l_q <= alpha_q);
  // shared incrementer: next new index, also the dead state
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign init_st    = ST_W'(cfg_i.initial_state);

  assign fm_we    = accept && (mode_e'(mode_i) == MODE_FLAG)
                    && (32'(state_index_i) < MAX_STATES);
  assign fm_raddr = (state_q == S_BLD_INIT) ? init_st : idx_q;

  assign tt_we    = accept && (mode_e'(mode_i) == MODE_TRANS)
                    && (32'(state_index_i) < MAX_STATES)
                    && (letter_i != '0) && (32'(letter_i) <= MAX_LETTERS);
  assign tt_waddr = {LT_W'(letter_i - LET_W'(1)), ST_W'(state_index_i)};
  assign tt_raddr = {LT_W'(l_q - LET_W'(1)), n2o_rd};

  assign o2n_we    = (state_q == S_BLD_WR);
  assign o2n_wdata = fm_rd ? '0 : cnt_inc;
  assign n2o_we    = (state_q == S_BLD_WR) && !fm_rd;

  dmpl_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_fm (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (ST_W'(state_index_i)),
    .wdata_i (final_flag_i),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rd)
  );

  dmpl_ram #(.WIDTH(ST_W), .DEPTH(TT_DEPTH)) u_tt (
    .clk_i   (clk_i),
    .we_i    (tt_we),
    .waddr_i (tt_waddr),
    .wdata_i (ST_W'(target_state_i)),
    .raddr_i (tt_raddr),
    .rdata_o (tt_rd)
  );

  dmpl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_STATES)) u_o2n (
    .clk_i   (clk_i),
    .we_i    (o2n_we),
    .waddr_i (idx_q),
    .wdata_i (o2n_wdata),
    .raddr_i (tt_rd),
    .rdata_o (o2n_rd)
  );

  dmpl_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_n2o (
    .clk_i   (clk_i),
    .we_i    (n2o_we),
    .waddr_i (cnt_q[ST_W-1:0]),
    .wdata_i (idx_q),
    .raddr_i (ST_W'(s_q - SIDX_W'(1))),
    .rdata_o (n2o_rd)
  );

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    l_d     = l_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    binit_d = binit_q;
    alpha_d = alpha_q;
    hi_d    = hi_q;
    built_d = built_q;
    eps_d   = eps_q;
    tgt_d   = tgt_q;
    fin_d   = fin_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          tgt_d = '0;
          fin_d = 1'b0;
          s_d   = state_index_i;
          l_d   = letter_i;
          case (mode_e'(mode_i))
            MODE_FLAG, MODE_TRANS: begin
              built_d = 1'b0;
              state_d = S_PUSH;
            end
            MODE_BUILD: begin
              built_d = 1'b1;
              alpha_d = (32'(cfg_i.letter_cnt) > MAX_LETTERS) ?
                        ALPHA_W'(MAX_LETTERS) : cfg_i.letter_cnt;
              hi_d    = ST_W'(cfg_i.last_state);
              state_d = S_BLD_INIT;
            end
            default: begin
              state_d = built_q ? S_RD_DEC : S_PUSH;
            end
          endcase
        end
      end
      S_BLD_INIT: begin
        idx_d   = '0;
        cnt_d   = '0;
        eps_d   = 1'b0;
        state_d = (init_st <= hi_q) ? S_BLD_CHK : S_BLD_RD;
      end
      S_BLD_CHK: begin
        if (fm_rd) begin
          eps_d   = 1'b1;
          state_d = S_PUSH;
        end else begin
          state_d = S_BLD_RD;
        end
      end
      S_BLD_RD: state_d = S_BLD_WR;
      S_BLD_WR: begin
        if (!fm_rd) begin
          cnt_d = cnt_inc;
        end
        if (idx_q == init_st) begin
          binit_d = o2n_wdata;
        end
        if (idx_q == hi_q) begin
          state_d = S_BLD_END;
        end else begin
          idx_d   = idx_q + ST_W'(1);
          state_d = S_BLD_RD;
        end
      end
      S_BLD_END: begin
        if (init_st > hi_q) begin
          binit_d = cnt_inc;
        end
        state_d = S_PUSH;
      end
      S_RD_DEC: begin
        state_d = S_PUSH;
        if (eps_q) begin
          if (s_q <= SIDX_W'(1)) begin
            fin_d = (s_q == '0);
            tgt_d = ok ? RES_W'(1) : '0;
          end
        end else if (s_q == '0) begin
          fin_d = 1'b1;
          tgt_d = ok ? RES_W'(cnt_inc) : '0;
        end else if (s_q <= SIDX_W'(cnt_q)) begin
          if (ok) begin
            state_d = S_RD_TT;
          end
        end else if (s_q == SIDX_W'(cnt_inc)) begin
          tgt_d = ok ? RES_W'(cnt_inc) : '0;
        end
      end
      S_RD_TT: state_d = S_RD_O2N;
      S_RD_O2N: begin
        // targets beyond the loaded automaton go dead
        if (tt_rd > hi_q) begin
          tgt_d   = RES_W'(cnt_inc);
          state_d = S_PUSH;
        end else begin
          state_d = S_RD_FIN;
        end
      end
      S_RD_FIN: begin
        tgt_d   = RES_W'(o2n_rd);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= 1'b0;
      eps_q   <= 1'b0;
      cnt_q   <= '0;
      binit_q <= '0;
      alpha_q <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      eps_q   <= eps_d;
      cnt_q   <= cnt_d;
      binit_q <= binit_d;
      alpha_q <= alpha_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    l_q   <= l_d;
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    fin_q <= fin_d;
  end

  assign res_valid_o      = (state_q == S_PUSH);
  assign res_o.target     = tgt_q;
  assign res_o.is_final   = fin_q;
  assign res_o.init_state = !built_q ? '0 : (eps_q ? '0 : RES_W'(binit_q));
  assign res_o.high_state = !built_q ? '0 : (eps_q ? RES_W'(1) : RES_W'(cnt_inc));
  assign res_o.built      = built_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLD_WR) |-> (cnt_q <= CNT_W'(idx_q)))
    else $error("nonfinal count ran ahead of the state walk");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_FLAG || mode_i == MODE_TRANS)) |=> !built_q)
    else $error("load did not clear built");

  a_tt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_TT) |-> ($past(state_q) == S_RD_DEC))
    else $error("table lookup without decode");

  a_read_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DEC) |-> built_q)
    else $error("result lookup before build");

endmodule
`default_nettype wire

// ===== sv/dfa_minimal_prefix_language.sv =====
// Loads, and reads before a build, go from accept straight to the result state;
// reads after a build decode first, then may read the RAMs in turn (new-to-old,
// transition, old-to-new: one RAM read each). Build: a read and a write state per
// state walked, 0..H for highest H; ends early when the initial state is final.
// One item at a time; in_ready_o is high again once the result beat leaves the core.
// rst_ni (async, active low) clears control and config registers, not the RAMs.
`default_nettype none
module dfa_minimal_prefix_language import dmpl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [MODE_W-1:0]  mode_i,
  input  wire logic [SIDX_W-1:0]  state_index_i,
  input  wire logic [LET_W-1:0]   letter_i,
  input  wire logic [TGT_W-1:0]   target_state_i,
  input  wire logic               final_flag_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [RES_W-1:0]   result_target_o,
  output      logic               result_final_o,
  output      logic [RES_W-1:0]   result_initial_o,
  output      logic [RES_W-1:0]   result_highest_o,
  output      logic               built_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  cfg_t cfg;
  res_t res, out_q, out_d;
  logic res_valid, res_ready;
  logic out_valid_q, out_valid_d;

  dmpl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmpl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .state_index_i  (state_index_i),
    .letter_i       (letter_i),
    .target_state_i (target_state_i),
    .final_flag_i   (final_flag_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output beat register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_target_o  = out_q.target;
  assign result_final_o   = out_q.is_final;
  assign result_initial_o = out_q.init_state;
  assign result_highest_o = out_q.high_state;
  assign built_o          = out_q.built;

endmodule
`default_nettype wire

// ===== test/dfa_minimal_prefix_language_test.sv =====
`timescale 1ns / 100ps
module dfa_minimal_prefix_language_test;
  import dmpl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;

  class prefix_dfa_scoreboard;
    bit               final_mark  [MAX_STATES];
    bit [TGT_W-1:0]   next_old    [MAX_LETTERS][MAX_STATES];
    bit [RES_W-1:0]   old_to_new  [MAX_STATES];
    bit [TGT_W-1:0]   new_to_old  [MAX_STATES];
    bit [RES_W-1:0]   live_count;
    bit               built;
    bit               eps_result;
    bit [RES_W-1:0]   new_initial;
    bit [ALPHA_W-1:0] letters_built;
    bit [ALPHA_W-1:0] alpha_reg = ALPHA_RST;
    bit [STATE_W-1:0] highest_reg;
    bit [STATE_W-1:0] initial_reg;
    res_t             owed_entries[$];
    int               results_seen;
    int               mismatches;
    int               builds;
    int               eps_builds;
    int               built_reads;

    function void set_reg(reg_e r, logic [PDATA_W-1:0] v);
      case (r)
        REG_ALPHA:   alpha_reg = v[ALPHA_W-1:0];
        REG_HIGHEST: highest_reg = v[STATE_W-1:0];
        default:     initial_reg = v[STATE_W-1:0];
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // nonfinal states become 1..count in index order, count+1 is dead,
    // every final state folds into new state 0
    function void build_min();
      int count;
      int dead;
      int i;
      count = 0;
      letters_built = (alpha_reg > MAX_LETTERS) ? ALPHA_W'(MAX_LETTERS) : alpha_reg;
      built = 1'b1;
      builds++;
      if (initial_reg <= highest_reg && final_mark[initial_reg]) begin
        eps_result = 1'b1;
        eps_builds++;
        return;
      end
      eps_result = 1'b0;
      for (i = 0; i <= int'(highest_reg); i++) begin
        if (!final_mark[i]) begin
          count++;
          old_to_new[i] = RES_W'(count);
          new_to_old[count-1] = TGT_W'(i);
        end else begin
          old_to_new[i] = '0;
        end
      end
      dead = count + 1;
      for (i = int'(highest_reg) + 1; i < MAX_STATES; i++) old_to_new[i] = RES_W'(dead);
      live_count = RES_W'(count);
      new_initial = (initial_reg <= highest_reg) ? old_to_new[initial_reg] : RES_W'(dead);
    endfunction

    function res_t predict_entry(mode_e m, logic [SIDX_W-1:0] s, logic [LET_W-1:0] l,
                                 logic [TGT_W-1:0] t, logic f);
      res_t           r;
      bit             ok;
      bit [RES_W-1:0] dead;
      r = '0;
      case (m)
        MODE_FLAG: begin
          if (s < MAX_STATES) final_mark[s[ST_W-1:0]] = f;
          built = 1'b0;
        end
        MODE_TRANS: begin
          if (s < MAX_STATES && l >= 1 && l <= MAX_LETTERS) next_old[l-1][s[ST_W-1:0]] = t;
          built = 1'b0;
        end
        MODE_BUILD: build_min();
        default: begin
          if (built) begin
            built_reads++;
            ok = (l >= 1 && l <= letters_built);
            dead = live_count + 1;
            if (eps_result) begin
              if (s <= 1) begin
                r.is_final = (s == 0);
                r.target = ok ? RES_W'(1) : '0;
              end
            end else if (s == 0) begin
              r.is_final = 1'b1;
              r.target = ok ? dead : '0;
            end else if (s <= live_count) begin
              if (ok) r.target = old_to_new[next_old[l-1][new_to_old[s-1]]];
            end else if (s == dead) begin
              r.target = ok ? dead : '0;
            end
          end
        end
      endcase
      if (built) begin
        r.init_state = eps_result ? '0 : new_initial;
        r.high_state = eps_result ? RES_W'(1) : live_count + 1;
      end
      r.built = built;
      return r;
    endfunction

    function void note_item(mode_e m, logic [SIDX_W-1:0] s, logic [LET_W-1:0] l,
                            logic [TGT_W-1:0] t, logic f);
      owed_entries.push_back(predict_entry(m, s, l, t, f));
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (owed_entries.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = owed_entries.pop_front();
      if (got.target !== want.target || got.is_final !== want.is_final ||
          got.init_state !== want.init_state || got.high_state !== want.high_state ||
          got.built !== want.built)
        report($sformatf({"exp/act target %0d/%0d final %0d/%0d initial %0d/%0d ",
                          "highest %0d/%0d built %0d/%0d"},
                         want.target, got.target, want.is_final, got.is_final,
                         want.init_state, got.init_state, want.high_state, got.high_state,
                         want.built, got.built));
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  mode_e              mode_i         = MODE_FLAG;
  logic [SIDX_W-1:0]  state_index_i  = '0;
  logic [LET_W-1:0]   letter_i       = '0;
  logic [TGT_W-1:0]   target_state_i = '0;
  logic               final_flag_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b1;
  logic [RES_W-1:0]   result_target_o;
  logic               result_final_o;
  logic [RES_W-1:0]   result_initial_o;
  logic [RES_W-1:0]   result_highest_o;
  logic               built_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  prefix_dfa_scoreboard chk;
  bit mark_loaded  [MAX_STATES];
  bit trans_loaded [MAX_LETTERS][MAX_STATES];
  int items_sent = 0;
  int settings   = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int cycle_cnt  = 0;

  dfa_minimal_prefix_language uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .state_index_i    (state_index_i),
    .letter_i         (letter_i),
    .target_state_i   (target_state_i),
    .final_flag_i     (final_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_target_o  (result_target_o),
    .result_final_o   (result_final_o),
    .result_initial_o (result_initial_o),
    .result_highest_o (result_highest_o),
    .built_o          (built_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // output stalls in bursts, each of random length
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (stall_pct > 0 && $urandom_range(99) < stall_pct) stall_left = $urandom_range(1, 4);
    out_ready_i <= (stall_left == 0);
  end

  // expectation is noted before the check so a same-edge result still finds it
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      chk.note_item(mode_i, state_index_i, letter_i, target_state_i, final_flag_i);
    if (rst_ni && out_valid_o && out_ready_i)
      chk.check_result({result_target_o, result_final_o, result_initial_o,
                        result_highest_o, built_o});
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout: %0d beats sent, %0d results seen", items_sent, chk.results_seen);
    $display("dfa_minimal_prefix_language_test failed");
    $finish;
  end

  function automatic int alpha_in_use();
    return (chk.alpha_reg > MAX_LETTERS) ? MAX_LETTERS : int'(chk.alpha_reg);
  endfunction

  function automatic logic [TGT_W-1:0] pick_target();
    if ($urandom_range(99) < 85) return TGT_W'($urandom_range(0, chk.highest_reg));
    return TGT_W'($urandom);
  endfunction

  function automatic logic [SIDX_W-1:0] pick_state();
    if ($urandom_range(99) < 88) return SIDX_W'($urandom_range(0, int'(chk.highest_reg) + 2));
    return SIDX_W'($urandom);
  endfunction

  function automatic logic [LET_W-1:0] pick_letter();
    int n;
    n = alpha_in_use();
    if (n != 0 && $urandom_range(99) < 85) return LET_W'($urandom_range(1, n));
    return LET_W'($urandom);
  endfunction

  task automatic send(mode_e m, logic [SIDX_W-1:0] s, logic [LET_W-1:0] l,
                      logic [TGT_W-1:0] t, logic f);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    state_index_i  <= s;
    letter_i       <= l;
    target_state_i <= t;
    final_flag_i   <= f;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic load_mark(logic [SIDX_W-1:0] s, logic f);
    send(MODE_FLAG, s, LET_W'($urandom), TGT_W'($urandom), f);
    if (s < MAX_STATES) mark_loaded[s[ST_W-1:0]] = 1'b1;
  endtask

  task automatic load_trans(logic [SIDX_W-1:0] s, logic [LET_W-1:0] l, logic [TGT_W-1:0] t);
    send(MODE_TRANS, s, l, t, 1'($urandom));
    if (s < MAX_STATES && l >= 1 && l <= MAX_LETTERS) trans_loaded[l-1][s[ST_W-1:0]] = 1'b1;
  endtask

  task automatic read_entry(logic [SIDX_W-1:0] s, logic [LET_W-1:0] l);
    send(MODE_READ, s, l, TGT_W'($urandom), 1'($urandom));
  endtask

  // every mark and every transition in use must hold loaded data before a build
  task automatic build_dfa();
    int n;
    int s;
    int l;
    n = alpha_in_use();
    for (s = 0; s <= int'(chk.highest_reg); s++) begin
      if (!mark_loaded[s]) load_mark(SIDX_W'(s), $urandom_range(3) == 0);
      for (l = 1; l <= n; l++)
        if (!trans_loaded[l-1][s]) load_trans(SIDX_W'(s), LET_W'(l), pick_target());
    end
    send(MODE_BUILD, SIDX_W'($urandom), LET_W'($urandom), TGT_W'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk.results_seen != items_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [PDATA_W-1:0] v);
    logic [PDATA_W-1:0] mask;
    mask = (r == REG_ALPHA) ? PDATA_W'(32'h1f) : PDATA_W'(32'hff);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chk.set_reg(r, v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (v & mask))
      chk.report($sformatf("register %s read back %h, wrote %h", r.name(), prdata, v));
  endtask

  task automatic set_cfg(int a, int h, int i0);
    settle();
    write_reg(REG_ALPHA, PDATA_W'(a));
    write_reg(REG_HIGHEST, PDATA_W'(h));
    write_reg(REG_INITIAL, PDATA_W'(i0));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  task automatic run_round();
    int n;
    int k;
    repeat ($urandom_range(0, 3)) read_entry(pick_state(), pick_letter());
    n = $urandom_range(0, 4);
    repeat (n) begin
      k = $urandom_range(9);
      if (k == 0)
        load_mark(SIDX_W'($urandom_range(MAX_STATES, 511)), 1'($urandom));
      else if (k == 1)
        load_trans(SIDX_W'($urandom), $urandom_range(1) ? LET_W'(0) :
                   LET_W'($urandom_range(MAX_LETTERS + 1, 31)), TGT_W'($urandom));
      else if (k < 6)
        load_mark(SIDX_W'($urandom_range(0, chk.highest_reg)), $urandom_range(3) == 0);
      else
        load_trans(SIDX_W'($urandom_range(0, chk.highest_reg)),
                   LET_W'($urandom_range(1, MAX_LETTERS)), pick_target());
    end
    build_dfa();
    repeat ($urandom_range(3, 10)) read_entry(pick_state(), pick_letter());
  endtask

  initial begin
    int a;
    int h;
    int i0;
    int p;
    chk = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing built yet, then loads that fall outside the tables
    read_entry(9'd0, 5'd1);
    read_entry(9'd511, 5'd31);
    load_mark(9'd511, 1'b1);
    load_trans(9'd256, 5'd1, 8'd5);
    load_trans(9'd0, 5'd0, 8'd3);
    load_trans(9'd1, 5'd17, 8'd255);

    set_cfg(3, 3, 0);
    load_mark(9'd0, 1'b0);
    load_mark(9'd1, 1'b1);
    load_mark(9'd2, 1'b0);
    load_mark(9'd3, 1'b0);
    load_trans(9'd0, 5'd1, 8'd1);    // into a final state
    load_trans(9'd0, 5'd2, 8'd200);  // past the highest state
    load_trans(9'd2, 5'd3, 8'd3);
    build_dfa();
    read_entry(9'd0, 5'd1);
    read_entry(9'd1, 5'd1);
    read_entry(9'd1, 5'd2);
    read_entry(9'd3, 5'd3);
    read_entry(9'd4, 5'd1);
    read_entry(9'd5, 5'd1);
    read_entry(9'd1, 5'd0);
    read_entry(9'd1, 5'd31);
    // initial state final: epsilon automaton
    load_mark(9'd0, 1'b1);
    build_dfa();
    read_entry(9'd0, 5'd3);
    read_entry(9'd1, 5'd2);
    read_entry(9'd2, 5'd1);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin a = 16; h = 7;   i0 = 2;   end
        1: begin a = 31; h = 5;   i0 = 9;   end
        2: begin a = 0;  h = 4;   i0 = 1;   end
        3: begin a = 1;  h = 255; i0 = 255; end
        4: begin a = 1;  h = 0;   i0 = 0;   end
        default: begin
          a = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
          h = $urandom_range(0, 11);
          i0 = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, h);
        end
      endcase
      set_cfg(a, h, i0);
      if (p >= PHASES - 2 || p == 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 15 * $urandom_range(1, 3);
        stall_pct = 15 * $urandom_range(0, 3);
      end
      repeat ((p == 3) ? 2 : 3) run_round();
    end

    settle();
    $display("%0d beats over %0d register settings; %0d builds, %0d of them epsilon",
             items_sent, settings, chk.builds, chk.eps_builds);
    $display("%0d reads of built entries checked, %0d mismatches",
             chk.built_reads, chk.mismatches);
    if (chk.mismatches == 0 && chk.owed_entries.size() == 0)
      $display("dfa_minimal_prefix_language_test passed");
    else
      $display("dfa_minimal_prefix_language_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/dmpl_pkg.sv
sv/dmpl_ram.sv
sv/dmpl_cfg.sv
sv/dmpl_core.sv
sv/dfa_minimal_prefix_language.sv
test/dfa_minimal_prefix_language_test.sv
